[rtl/core/mwp_pkg.sv]
// ----------------------------------------------------------------------------
// mwp_pkg - shared types and constants of the matrix word penalty unit
// Operation codes, sequencer states, multiplier control and the fixed
// widths and constants of the scoring rule.
// ----------------------------------------------------------------------------
package mwp_pkg;

    localparam int MAX_WIDTH_DEF    = 8;
    localparam int LETTER_COUNT_DEF = 4;

    localparam int DATA_W   = 32;
    localparam int CFG_W    = 4;
    localparam int LETTER_W = 2;
    localparam int POS_W    = 3;

    localparam logic [CFG_W-1:0]         WIDTH_RESET    = 4'd5;
    localparam logic [DATA_W-1:0]        TOP_COST_SCALE = 32'd10000;
    localparam logic signed [DATA_W-1:0] COST_CAP       = 32'sd1000000;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_LEFT   = 2'd1,
        OP_RIGHT  = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COPY_WAIT,
        ST_MUL,
        ST_MUL_WAIT,
        ST_BACK,
        ST_FIN_RD,
        ST_FIN_LAT,
        ST_FIN_M1,
        ST_FIN_M2,
        ST_FIN_ACC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_first;
    } mac_ctrl_t;

endpackage

[rtl/core/mwp_ram.sv]
// ----------------------------------------------------------------------------
// mwp_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mwp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/mwp_mac.sv]
// ----------------------------------------------------------------------------
// mwp_mac - shared multiply-accumulate unit
// One 32x32 multiplier keeping the low 32 bits, a product register and an
// accumulator that either loads or adds the registered product.
// ----------------------------------------------------------------------------
module mwp_mac
    import mwp_pkg::*;
(
    input  logic              aclk,
    input  mac_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] op_a,
    input  logic [DATA_W-1:0] op_b,
    output logic [DATA_W-1:0] prod,
    output logic [DATA_W-1:0] acc
);

    logic [DATA_W-1:0] full_prod;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;

    assign full_prod = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= full_prod;
        end
        if (ctrl.acc_en) begin
            acc_reg <= ctrl.acc_first ? prod_reg : acc_reg + prod_reg;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

[rtl/core/matrix_word_penalty_unit.sv]
// ----------------------------------------------------------------------------
// matrix_word_penalty_unit - scores a left word against a right word
// Per-letter matrix store, running products per side and a finish scorer,
// all sharing one multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the s_ stream (op in s_tuser). A write request
// stores one matrix entry. A letter request appends a letter to the left
// or right word: the first letter of a word copies the letter's matrix;
// each later letter multiplies the running product on the right, one
// multiply-accumulate per cycle through the shared multiplier, then copies
// the scratch product back. A finish request scores the two products
// (read, latch, two multiplies, accumulate per entry) and places
// penalty_sum in the m_ output register, then clears both words.
// w is the width set on the cfg_ port (clamped to 2..MAX_WIDTH); write it
// only while the block is idle. s_tready is high only while the sequencer
// idles. A stalled receiver holds the result in the output register; the
// block keeps taking requests, and only a second finish waits for the slot.
// Reset (aresetn low, synchronous) empties both words, sets w to 5 and
// drops any pending result; letter matrices keep whatever they held.
// ----------------------------------------------------------------------------
module matrix_word_penalty_unit
    import mwp_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int LETTER_COUNT = LETTER_COUNT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_width_in_use,
    // request stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // letter[1:0], row[4:2], col[7:5], entry_value[39:8]
    input  logic [1:0]       s_tuser,   // op[1:0]
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata    // penalty_sum[31:0]
);

    localparam int IDX_W     = $clog2(MAX_WIDTH);
    localparam int CELL_W    = 2 * IDX_W;
    localparam int CELLS_P   = 1 << CELL_W;
    localparam int LET_W     = (LETTER_COUNT > 1) ? $clog2(LETTER_COUNT) : 1;
    localparam int LET_DEPTH = 1 << (LET_W + CELL_W);

    // request fields
    op_t                 s_op;
    logic [LETTER_W-1:0] s_letter;
    logic [POS_W-1:0]    s_row;
    logic [POS_W-1:0]    s_col;
    logic [DATA_W-1:0]   s_value;
    logic                accept;
    logic                letter_ok;
    logic                pos_ok;
    logic [LET_W-1:0]    let_idx;

    state_t state_reg, state_next;
    logic [CFG_W-1:0] cfg_reg;
    logic [IDX_W-1:0] w_m1;

    logic             side_reg;
    logic [LET_W-1:0] let_reg;
    logic [IDX_W-1:0] cnt_i_reg, cnt_i_next;
    logic [IDX_W-1:0] cnt_j_reg, cnt_j_next;
    logic [IDX_W-1:0] cnt_k_reg, cnt_k_next;
    logic             i_last, j_last, k_last;

    logic               left_started_reg, right_started_reg;
    logic [CELLS_P-1:0] left_vld_reg, left_vld_next;
    logic [CELLS_P-1:0] right_vld_reg, right_vld_next;

    // sweep pipeline
    logic              iss_cp, iss_mac;
    logic              p1_cp_reg, p1_scr_reg, p1_mac_reg;
    logic              p1_first_reg, p1_last_reg;
    logic              p1_lv_reg, p1_rv_reg, p1_diag_reg;
    logic [CELL_W-1:0] p1_cell_reg;
    logic              p2_mac_reg, p2_first_reg, p2_last_reg;
    logic [CELL_W-1:0] p2_cell_reg;
    logic              p3_wr_reg;
    logic [CELL_W-1:0] p3_cell_reg;

    // memories
    logic [LET_W+CELL_W-1:0] let_waddr, let_raddr;
    logic                    let_we;
    logic [DATA_W-1:0]       let_q;
    logic [CELL_W-1:0]       prod_raddr;
    logic                    left_we, right_we;
    logic [DATA_W-1:0]       prod_wdata;
    logic [DATA_W-1:0]       left_q, right_q;
    logic [DATA_W-1:0]       scr_q;

    // arithmetic
    mac_ctrl_t         mac_ctrl;
    logic [DATA_W-1:0] mac_a, mac_b, mac_prod, mac_acc;
    logic [DATA_W-1:0] left_val, right_val;
    logic [DATA_W-1:0] x_reg, y_reg, t_reg;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic              top_cell;
    logic              cost_bad;
    logic [DATA_W-1:0] cost_raw, cost;

    logic              out_free, emit_fire;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg;

    // ---------------- request decode ----------------
    assign s_op      = op_t'(s_tuser);
    assign s_letter  = s_tdata[1:0];
    assign s_row     = s_tdata[4:2];
    assign s_col     = s_tdata[7:5];
    assign s_value   = s_tdata[39:8];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign letter_ok = 32'(s_letter) < LETTER_COUNT;
    assign pos_ok    = (32'(s_row) < MAX_WIDTH) && (32'(s_col) < MAX_WIDTH);
    assign let_idx   = LET_W'(s_letter);

    assign cfg_ready = 1'b1;

    // clamp the width in use to 2..MAX_WIDTH, kept as w-1
    always_comb begin
        if (cfg_reg < 4'd2) begin
            w_m1 = IDX_W'(1);
        end else if (32'(cfg_reg) > MAX_WIDTH) begin
            w_m1 = IDX_W'(MAX_WIDTH - 1);
        end else begin
            w_m1 = IDX_W'(cfg_reg - 4'd1);
        end
    end

    assign i_last = (cnt_i_reg == w_m1);
    assign j_last = (cnt_j_reg == w_m1);
    assign k_last = (cnt_k_reg == w_m1);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        OP_WRITE: state_next = ST_IDLE;
                        OP_LEFT: begin
                            if (letter_ok) begin
                                state_next = left_started_reg ? ST_MUL : ST_LOAD;
                            end
                        end
                        OP_RIGHT: begin
                            if (letter_ok) begin
                                state_next = right_started_reg ? ST_MUL : ST_LOAD;
                            end
                        end
                        OP_FINISH: state_next = ST_FIN_RD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                if (i_last && j_last) begin
                    state_next = ST_COPY_WAIT;
                end
            end
            ST_COPY_WAIT: state_next = ST_IDLE;
            ST_MUL: begin
                if (i_last && k_last && j_last) begin
                    state_next = ST_MUL_WAIT;
                end
            end
            ST_MUL_WAIT: begin
                if (!p1_mac_reg && !p2_mac_reg && !p3_wr_reg) begin
                    state_next = ST_BACK;
                end
            end
            ST_BACK: begin
                if (i_last && j_last) begin
                    state_next = ST_COPY_WAIT;
                end
            end
            ST_FIN_RD:  state_next = ST_FIN_LAT;
            ST_FIN_LAT: state_next = ST_FIN_M1;
            ST_FIN_M1:  state_next = ST_FIN_M2;
            ST_FIN_M2:  state_next = ST_FIN_ACC;
            ST_FIN_ACC: state_next = (i_last && j_last) ? ST_EMIT : ST_FIN_RD;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        iss_cp     = 1'b0;
        iss_mac    = 1'b0;
        cnt_i_next = cnt_i_reg;
        cnt_j_next = cnt_j_reg;
        cnt_k_next = cnt_k_reg;
        let_raddr  = {let_reg, cnt_i_reg, cnt_j_reg};
        mac_a      = side_reg ? right_val : left_val;
        mac_b      = let_q;
        mac_ctrl   = '{mul_en: p1_mac_reg, acc_en: p2_mac_reg, acc_first: p2_first_reg};
        unique case (state_reg)
            ST_IDLE: begin
                cnt_i_next = '0;
                cnt_j_next = '0;
                cnt_k_next = '0;
            end
            ST_LOAD, ST_BACK, ST_FIN_ACC: begin
                iss_cp = (state_reg != ST_FIN_ACC);
                // sweep columns inside rows
                cnt_j_next = j_last ? '0 : cnt_j_reg + 1'b1;
                if (j_last) begin
                    cnt_i_next = i_last ? '0 : cnt_i_reg + 1'b1;
                end
            end
            ST_MUL: begin
                iss_mac   = 1'b1;
                let_raddr = {let_reg, cnt_j_reg, cnt_k_reg};
                // dot product index innermost, then result column, then row
                cnt_j_next = j_last ? '0 : cnt_j_reg + 1'b1;
                if (j_last) begin
                    cnt_k_next = k_last ? '0 : cnt_k_reg + 1'b1;
                    if (k_last) begin
                        cnt_i_next = i_last ? '0 : cnt_i_reg + 1'b1;
                    end
                end
            end
            ST_FIN_M1: begin
                mac_ctrl = '{mul_en: 1'b1, acc_en: 1'b0, acc_first: 1'b0};
                if (top_cell) begin
                    mac_a = TOP_COST_SCALE;
                    mac_b = y_reg - x_reg + 32'd1;
                end else begin
                    mac_a = y_reg;
                    mac_b = y_reg;
                end
            end
            ST_FIN_M2: begin
                mac_ctrl = '{mul_en: 1'b1, acc_en: 1'b0, acc_first: 1'b0};
                mac_a    = x_reg;
                mac_b    = x_reg;
            end
            default: begin
            end
        endcase
    end

    assign prod_raddr = {cnt_i_reg, cnt_j_reg};
    assign let_we     = accept && (s_op == OP_WRITE) && letter_ok && pos_ok;
    assign let_waddr  = {let_idx, IDX_W'(s_row), IDX_W'(s_col)};
    assign prod_wdata = p1_scr_reg ? scr_q : let_q;
    assign left_we    = p1_cp_reg && !side_reg;
    assign right_we   = p1_cp_reg && side_reg;

    // entries never written since the word was cleared read as identity
    assign left_val  = p1_lv_reg ? left_q  : {{(DATA_W-1){1'b0}}, p1_diag_reg};
    assign right_val = p1_rv_reg ? right_q : {{(DATA_W-1){1'b0}}, p1_diag_reg};

    // ---------------- finish scoring ----------------
    assign top_cell = (cnt_i_reg == '0) && j_last;

    always_comb begin
        if (top_cell) begin
            cost_bad = !($signed(x_reg) > $signed(y_reg));
            cost_raw = t_reg;
        end else begin
            cost_bad = $signed(x_reg) < $signed(y_reg);
            cost_raw = t_reg - mac_prod;
        end
        cost = cost_bad ? cost_raw : '0;
        if ($signed(cost) > COST_CAP) begin
            cost = COST_CAP;
        end
    end

    always_comb begin
        sum_next = sum_reg;
        if (accept) begin
            sum_next = '0;
        end else if (state_reg == ST_FIN_ACC) begin
            sum_next = sum_reg + cost;
        end
    end

    // ---------------- output register ----------------
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- entry valid bits ----------------
    always_comb begin
        left_vld_next  = left_vld_reg;
        right_vld_next = right_vld_reg;
        if (emit_fire) begin
            left_vld_next  = '0;
            right_vld_next = '0;
        end else begin
            if (left_we) begin
                left_vld_next[p1_cell_reg] = 1'b1;
            end
            if (right_we) begin
                right_vld_next[p1_cell_reg] = 1'b1;
            end
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            cfg_reg           <= WIDTH_RESET;
            left_started_reg  <= 1'b0;
            right_started_reg <= 1'b0;
            left_vld_reg      <= '0;
            right_vld_reg     <= '0;
            p1_cp_reg         <= 1'b0;
            p1_mac_reg        <= 1'b0;
            p2_mac_reg        <= 1'b0;
            p3_wr_reg         <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            left_vld_reg  <= left_vld_next;
            right_vld_reg <= right_vld_next;
            p1_cp_reg     <= iss_cp;
            p1_mac_reg    <= iss_mac;
            p2_mac_reg    <= p1_mac_reg;
            p3_wr_reg     <= p2_mac_reg && p2_last_reg;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_width_in_use;
            end
            if (emit_fire) begin
                left_started_reg  <= 1'b0;
                right_started_reg <= 1'b0;
            end else if (accept && letter_ok) begin
                if (s_op == OP_LEFT) begin
                    left_started_reg <= 1'b1;
                end
                if (s_op == OP_RIGHT) begin
                    right_started_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        cnt_i_reg <= cnt_i_next;
        cnt_j_reg <= cnt_j_next;
        cnt_k_reg <= cnt_k_next;
        sum_reg   <= sum_next;
        if (accept) begin
            side_reg <= (s_op == OP_RIGHT);
            let_reg  <= let_idx;
        end
        p1_scr_reg   <= (state_reg == ST_BACK);
        p1_first_reg <= (cnt_j_reg == '0);
        p1_last_reg  <= j_last;
        p1_cell_reg  <= (state_reg == ST_MUL) ? {cnt_i_reg, cnt_k_reg}
                                              : {cnt_i_reg, cnt_j_reg};
        p1_lv_reg    <= left_vld_reg[prod_raddr];
        p1_rv_reg    <= right_vld_reg[prod_raddr];
        p1_diag_reg  <= (cnt_i_reg == cnt_j_reg);
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_cell_reg  <= p1_cell_reg;
        p3_cell_reg  <= p2_cell_reg;
        if (state_reg == ST_FIN_LAT) begin
            x_reg <= left_val;
            y_reg <= right_val;
        end
        if (state_reg == ST_FIN_M2) begin
            t_reg <= mac_prod;
        end
        if (emit_fire) begin
            m_tdata_reg <= sum_reg;
        end
    end

    // ---------------- instances ----------------
    mwp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LET_DEPTH)
    ) u_letter_ram (
        .aclk  (aclk),
        .we    (let_we),
        .waddr (let_waddr),
        .wdata (s_value),
        .raddr (let_raddr),
        .rdata (let_q)
    );

    mwp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS_P)
    ) u_left_ram (
        .aclk  (aclk),
        .we    (left_we),
        .waddr (p1_cell_reg),
        .wdata (prod_wdata),
        .raddr (prod_raddr),
        .rdata (left_q)
    );

    mwp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS_P)
    ) u_right_ram (
        .aclk  (aclk),
        .we    (right_we),
        .waddr (p1_cell_reg),
        .wdata (prod_wdata),
        .raddr (prod_raddr),
        .rdata (right_q)
    );

    mwp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS_P)
    ) u_scratch_ram (
        .aclk  (aclk),
        .we    (p3_wr_reg),
        .waddr (p3_cell_reg),
        .wdata (mac_acc),
        .raddr ({cnt_i_reg, cnt_j_reg}),
        .rdata (scr_q)
    );

    mwp_mac u_mac (
        .aclk  (aclk),
        .ctrl  (mac_ctrl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .prod  (mac_prod),
        .acc   (mac_acc)
    );

`ifndef SYNTHESIS
    a_scratch_wr_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        p3_wr_reg |-> (state_reg == ST_MUL || state_reg == ST_MUL_WAIT))
        else $error("scratch write outside multiply phase");

    a_copy_wr_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_cp_reg |-> (state_reg == ST_LOAD || state_reg == ST_BACK
                       || state_reg == ST_COPY_WAIT))
        else $error("product copy write outside copy phase");

    a_back_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BACK) |-> (!p2_mac_reg && !p3_wr_reg))
        else $error("copy-back started with products still in flight");

    a_words_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> (left_vld_reg == '0 && right_vld_reg == '0
                       && !left_started_reg && !right_started_reg))
        else $error("words not cleared after finish");
`endif

endmodule
